// ===== rtl/vn_pkg.sv =====
`timescale 1ns / 1ps
// Package for the 3D vector normalizer: widths, payload structs and the
// per-item record handed along the cell chain. No dependencies.
package vn_pkg;

   // Field widths of the input and result items.
   localparam int InWidth = 16;
   localparam int OutFracBits = 14;
   localparam int OutWidth = OutFracBits + 2;

   // Internal widths: sum of squares, scaled square, residue, running product.
   localparam int SumWidth = 2 * InWidth + 2;
   localparam int ScaledWidth = 2 * InWidth + 2 * OutFracBits + 1;
   localparam int ResWidth = 2 * InWidth + 2 * OutFracBits + 6;
   localparam int ProdWidth = 2 * InWidth + OutFracBits + 5;
   localparam int QuotWidth = OutFracBits + 1;
   localparam int NumCells = OutFracBits + 1;

   typedef struct packed {
      logic signed [InWidth-1:0] x_in;
      logic signed [InWidth-1:0] y_in;
      logic signed [InWidth-1:0] z_in;
   } req_type;

   typedef struct packed {
      logic signed [OutWidth-1:0] x_unit;
      logic signed [OutWidth-1:0] y_unit;
      logic signed [OutWidth-1:0] z_unit;
      logic                       zero_vector;
   } rsp_type;

   // One component on its way through the cells.
   typedef struct packed {
      logic signed [ResWidth-1:0]  res;
      logic signed [ProdWidth-1:0] prod;
      logic [QuotWidth-1:0]        quot;
      logic                        neg;
   } lane_type;

   typedef struct packed {
      lane_type [2:0]        lane;
      logic [SumWidth-1:0]   sum;
      logic                  zero;
   } item_type;

endpackage

// ===== rtl/vn_front.sv =====
`timescale 1ns / 1ps
// Front end of the normalizer: magnitudes and squares, then the sum of
// squares and the starting residues for the cell chain. Uses vn_pkg.
module vn_front import vn_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  req_type  in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_data
);

   logic                       a_valid_ff, a_valid_in, a_ready;
   logic [2*InWidth-1:0]       sq_ff [3];
   logic [2:0]                 neg_ff;
   logic                       b_valid_ff, b_valid_in;
   item_type                   item_ff, item_in;
   logic signed [InWidth-1:0]  comp [3];
   logic [InWidth:0]           mag_wide [3];
   logic [InWidth-1:0]         mag [3];
   logic [SumWidth-1:0]        sum;
   logic [ScaledWidth-1:0]     scaled [3];

   assign comp[0] = in_data.x_in;
   assign comp[1] = in_data.y_in;
   assign comp[2] = in_data.z_in;

   // Stage A handshake: takes an item when empty or when stage B takes ours.
   assign a_ready = !b_valid_ff || out_ready;
   assign in_ready = !a_valid_ff || a_ready;
   assign a_valid_in = in_ready ? in_valid : a_valid_ff;

   // Absolute values; the most negative input still fits unsigned.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_wide[i] = comp[i][InWidth-1] ? -{comp[i][InWidth-1], comp[i]}
                                          : {comp[i][InWidth-1], comp[i]};
         mag[i] = mag_wide[i][InWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      if (in_ready && in_valid) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= mag[i] * mag[i];
            neg_ff[i] <= comp[i][InWidth-1];
         end
      end
   end

   // Stage B: sum of squares, and for each lane the residue
   // m^2 * 4^(F+1) - s with the running product at -s.
   assign b_valid_in = a_ready ? a_valid_ff : b_valid_ff;

   always_comb begin
      sum = SumWidth'(sq_ff[0]) + SumWidth'(sq_ff[1]) + SumWidth'(sq_ff[2]);
      item_in.sum = sum;
      item_in.zero = (sum == '0);
      for (int i = 0; i < 3; i++) begin
         scaled[i] = ScaledWidth'(sq_ff[i]) << (2 * OutFracBits + 2);
         item_in.lane[i].res = $signed(ResWidth'(scaled[i])) - $signed(ResWidth'(sum));
         item_in.lane[i].prod = -$signed(ProdWidth'(sum));
         item_in.lane[i].quot = '0;
         item_in.lane[i].neg = neg_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
      if (a_ready && a_valid_ff) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data = item_ff;

endmodule

// ===== rtl/vn_cell.sv =====
`timescale 1ns / 1ps
// One cell of the normalizer chain: settles one result bit of all three
// components by shift, subtract and sign test. Uses vn_pkg.
module vn_cell import vn_pkg::*; #(
   parameter int BIT = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_data
);

   logic                       valid_ff, valid_in;
   item_type                   item_ff, item_in;
   logic signed [ResWidth-1:0] trial [3];
   logic signed [ResWidth-1:0] sum_res;
   logic signed [ProdWidth-1:0] sum_prod;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // With u = 2q - 1 the residue is m^2 4^(F+1) - u^2 s and prod is u s.
   // Setting bit BIT adds 2^(BIT+1) to u, so the residue drops by
   // prod 2^(BIT+2) + s 4^(BIT+1); the bit stays if the residue stays >= 0.
   always_comb begin
      sum_res = $signed(ResWidth'(in_data.sum));
      sum_prod = $signed(ProdWidth'(in_data.sum));
      item_in = in_data;
      for (int i = 0; i < 3; i++) begin
         trial[i] = in_data.lane[i].res
                    - (ResWidth'(in_data.lane[i].prod) <<< (BIT + 2))
                    - (sum_res <<< (2 * BIT + 2));
         if (!trial[i][ResWidth-1]) begin
            item_in.lane[i].res = trial[i];
            item_in.lane[i].prod = in_data.lane[i].prod + (sum_prod <<< (BIT + 1));
            item_in.lane[i].quot[BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = item_ff;

endmodule

// ===== rtl/vector3_normalize.sv =====
`timescale 1ns / 1ps
// Channel   Ports                            Moves
// req       req_valid/req_ready/req_data     one input vector per item
// rsp       rsp_valid/rsp_ready/rsp_data     one unit vector per item
//
// Stages in order: two front stages, one cell per result bit
// (OutFracBits + 1 cells), and the output register.
// One item can enter every cycle while rsp_ready is high; each stage holds one item.
// Reset is synchronous and empties every stage.
// A stalled result holds its stage; earlier stages keep filling until full.
// Top level of the 3D vector normalizer; uses vn_pkg, vn_front, vn_cell.
module vector3_normalize import vn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   item_type chain_data  [NumCells+1];
   logic     chain_valid [NumCells+1];
   logic     chain_ready [NumCells+1];
   logic     out_valid_ff, out_valid_in;
   rsp_type  out_ff, out_in;
   logic signed [OutWidth-1:0] unit [3];

   vn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   // Cell k settles result bit OutFracBits - k.
   for (genvar k = 0; k < NumCells; k++) begin : g_cell
      vn_cell #(.BIT(OutFracBits - k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_data   (chain_data[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_data  (chain_data[k+1])
      );
   end

   // Output register: sign applied, zero vector forced to zero.
   assign chain_ready[NumCells] = !out_valid_ff || rsp_ready;
   assign out_valid_in = chain_ready[NumCells] ? chain_valid[NumCells] : out_valid_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         unit[i] = chain_data[NumCells].lane[i].neg
                   ? -$signed(OutWidth'(chain_data[NumCells].lane[i].quot))
                   : $signed(OutWidth'(chain_data[NumCells].lane[i].quot));
         if (chain_data[NumCells].zero) begin
            unit[i] = '0;
         end
      end
      out_in.x_unit = unit[0];
      out_in.y_unit = unit[1];
      out_in.z_unit = unit[2];
      out_in.zero_vector = chain_data[NumCells].zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (chain_ready[NumCells] && chain_valid[NumCells]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;

   // A zero vector always comes out with zero components.
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_vector |->
      rsp_data.x_unit == '0 && rsp_data.y_unit == '0 && rsp_data.z_unit == '0)
      else $error("zero vector with nonzero components");

   // Results never exceed full scale.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
      rsp_data.x_unit <= $signed(OutWidth'(1 << OutFracBits)) &&
      rsp_data.x_unit >= -$signed(OutWidth'(1 << OutFracBits)) &&
      rsp_data.y_unit <= $signed(OutWidth'(1 << OutFracBits)) &&
      rsp_data.y_unit >= -$signed(OutWidth'(1 << OutFracBits)) &&
      rsp_data.z_unit <= $signed(OutWidth'(1 << OutFracBits)) &&
      rsp_data.z_unit >= -$signed(OutWidth'(1 << OutFracBits)))
      else $error("result beyond full scale");

   // With the output stage empty nothing can block the input.
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked while output stage is empty");

endmodule
